// ===== rtl/hsv_pkg.sv =====
`timescale 1ns / 1ps

package hsv_pkg;

  // Default channel width
  localparam int CHANNEL_BITS_DEF = 8;

  // Hue output width and the black-pixel code (-1)
  localparam int HUE_BITS = 10;
  localparam logic [HUE_BITS-1:0] HUE_BLACK = '1;

  // Hue quotient is below 360, so it needs at least nine bits
  localparam int MIN_QUO_BITS = 9;

  // Hexcone sector of the maximal channel
  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

endpackage

// ===== rtl/rgb_to_hsv_converter_top.sv =====
`timescale 1ns / 1ps
// From start to done a pixel passes stages 1 to 4, the two dividers and the output register.
// Throughput: one pixel per cycle; busy stays low and a pixel may enter every cycle.
// The two dividers are pipelined and resolve one quotient bit per stage.
// Reset (rst, synchronous) clears the valid bits of all stages; data registers keep junk.
// The receiver cannot stall: each result shows on done for exactly one cycle.

module rgb_to_hsv_converter_top #(
  parameter int CHANNEL_BITS = hsv_pkg::CHANNEL_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [CHANNEL_BITS-1:0]               red,
  input  logic [CHANNEL_BITS-1:0]               green,
  input  logic [CHANNEL_BITS-1:0]               blue,
  output logic                                  done,
  output logic signed [hsv_pkg::HUE_BITS-1:0]   hue,
  output logic [CHANNEL_BITS-1:0]               saturation,
  output logic [CHANNEL_BITS-1:0]               brightness
);

  localparam int N   = CHANNEL_BITS;
  localparam int Q   = (N > hsv_pkg::MIN_QUO_BITS) ? N : hsv_pkg::MIN_QUO_BITS;
  localparam int DW  = N + Q;
  localparam int TW  = N + 4;
  localparam int LAT = 5 + Q;

  logic accept;

  // The pipeline never stalls
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // ---------------------------------------------------------------- stage 1
  logic                     max_sel_r;
  logic                     max_sel_g;
  hsv_pkg::sector_t         sec_c;
  logic [N-1:0]             mx_c;
  logic [N-1:0]             mn_c;
  logic signed [N:0]        diff_c;

  // Pick the maximal channel, red first, then green, then blue
  always_comb begin
    max_sel_r = (red >= green) && (red >= blue);
    max_sel_g = green >= blue;
    priority if (max_sel_r) begin
      sec_c  = hsv_pkg::SEC_RED;
      mx_c   = red;
      diff_c = $signed({1'b0, green}) - $signed({1'b0, blue});
    end else if (max_sel_g) begin
      sec_c  = hsv_pkg::SEC_GREEN;
      mx_c   = green;
      diff_c = $signed({1'b0, blue}) - $signed({1'b0, red});
    end else begin
      sec_c  = hsv_pkg::SEC_BLUE;
      mx_c   = blue;
      diff_c = $signed({1'b0, red}) - $signed({1'b0, green});
    end
  end

  // Find the minimal channel
  always_comb begin
    mn_c = (red <= green) ? red : green;
    if (blue < mn_c) begin
      mn_c = blue;
    end
  end

  logic                     s1_valid;
  hsv_pkg::sector_t         s1_sec;
  logic [N-1:0]             s1_mx;
  logic [N-1:0]             s1_mn;
  logic signed [N:0]        s1_diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_sec  <= sec_c;
    s1_mx   <= mx_c;
    s1_mn   <= mn_c;
    s1_diff <= diff_c;
  end

  // ---------------------------------------------------------------- stage 2
  logic                     s2_valid;
  hsv_pkg::sector_t         s2_sec;
  logic [N-1:0]             s2_mx;
  logic [N-1:0]             s2_delta;
  logic signed [N:0]        s2_diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  // Form delta = max - min
  always_ff @(posedge clk) begin
    s2_sec   <= s1_sec;
    s2_mx    <= s1_mx;
    s2_delta <= s1_mx - s1_mn;
    s2_diff  <= s1_diff;
  end

  // ---------------------------------------------------------------- stage 3
  logic signed [TW-1:0]     dx;
  logic signed [TW-1:0]     diffx;
  logic signed [TW-1:0]     six_d;
  logic signed [TW-1:0]     t_c;

  // Hue numerator over 60: offset * delta + diff, wrapped by 6 * delta when negative
  always_comb begin
    dx    = $signed({4'b0000, s2_delta});
    diffx = $signed({{3{s2_diff[N]}}, s2_diff});
    six_d = (dx <<< 2) + (dx <<< 1);
    unique case (s2_sec)
      hsv_pkg::SEC_RED: begin
        t_c = s2_diff[N] ? diffx + six_d : diffx;
      end
      hsv_pkg::SEC_GREEN: begin
        t_c = diffx + (dx <<< 1);
      end
      hsv_pkg::SEC_BLUE: begin
        t_c = diffx + (dx <<< 2);
      end
      default: begin
        t_c = diffx;
      end
    endcase
  end

  logic                     s3_valid;
  logic [N-1:0]             s3_mx;
  logic [N-1:0]             s3_delta;
  logic [N+2:0]             s3_t;
  logic                     s3_black;
  logic                     s3_grey;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_mx    <= s2_mx;
    s3_delta <= s2_delta;
    s3_t     <= t_c[N+2:0];
    s3_black <= (s2_mx == '0);
    s3_grey  <= (s2_delta == '0);
  end

  // ---------------------------------------------------------------- stage 4
  logic [N+8:0]             hue_num_c;
  logic [2*N-1:0]           sat_num_c;

  // Scale by 60 and by full scale with shift-and-subtract
  assign hue_num_c = {s3_t, 6'b000000} - {4'b0000, s3_t, 2'b00};
  assign sat_num_c = {s3_delta, {N{1'b0}}} - {{N{1'b0}}, s3_delta};

  logic                     s4_valid;
  logic [N-1:0]             s4_mx;
  logic [N-1:0]             s4_delta;
  logic [DW-1:0]            s4_hue_num;
  logic [DW-1:0]            s4_sat_num;
  logic                     s4_black;
  logic                     s4_grey;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    s4_mx      <= s3_mx;
    s4_delta   <= s3_delta;
    s4_hue_num <= DW'(hue_num_c);
    s4_sat_num <= DW'(sat_num_c);
    s4_black   <= s3_black;
    s4_grey    <= s3_grey;
  end

  // ---------------------------------------------------------------- dividers
  logic [Q-1:0]             hue_q;
  logic [Q-1:0]             sat_q;

  hsv_div #(
    .DVS_BITS (N),
    .QUO_BITS (Q)
  ) u_hue_div (
    .clk      (clk),
    .dividend (s4_hue_num),
    .divisor  (s4_delta),
    .quotient (hue_q)
  );

  hsv_div #(
    .DVS_BITS (N),
    .QUO_BITS (Q)
  ) u_sat_div (
    .clk      (clk),
    .dividend (s4_sat_num),
    .divisor  (s4_mx),
    .quotient (sat_q)
  );

  // Carry valid and side data alongside the divider stages
  logic                     dv_valid [Q];
  logic [N-1:0]             dv_mx    [Q];
  logic                     dv_black [Q];
  logic                     dv_grey  [Q];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < Q; i++) begin
        dv_valid[i] <= 1'b0;
      end
    end else begin
      dv_valid[0] <= s4_valid;
      for (int i = 1; i < Q; i++) begin
        dv_valid[i] <= dv_valid[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    dv_mx[0]    <= s4_mx;
    dv_black[0] <= s4_black;
    dv_grey[0]  <= s4_grey;
    for (int i = 1; i < Q; i++) begin
      dv_mx[i]    <= dv_mx[i-1];
      dv_black[i] <= dv_black[i-1];
      dv_grey[i]  <= dv_grey[i-1];
    end
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_valid[Q-1];
    end
  end

  // Override hue and saturation for black and grey pixels
  always_ff @(posedge clk) begin
    brightness <= dv_mx[Q-1];
    if (dv_black[Q-1]) begin
      hue        <= hsv_pkg::HUE_BLACK;
      saturation <= '0;
    end else begin
      hue        <= dv_grey[Q-1] ? '0 :
                    hsv_pkg::HUE_BITS'(hue_q[hsv_pkg::MIN_QUO_BITS-1:0]);
      saturation <= sat_q[N-1:0];
    end
  end

  // ---------------------------------------------------------------- checks
  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LAT))
    else $error("result without a pixel accepted %0d cycles earlier", LAT);

  a_black_codes: assert property (@(posedge clk) disable iff (rst)
    (done && brightness == '0) |-> (hue == hsv_pkg::HUE_BLACK && saturation == '0))
    else $error("black pixel without black hue and zero saturation");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    (done && hue != hsv_pkg::HUE_BLACK) |-> ($unsigned(hue) < 10'd360))
    else $error("hue out of range");

  a_grey_hue: assert property (@(posedge clk) disable iff (rst)
    (done && saturation == '0 && brightness != '0) |-> (hue == '0))
    else $error("grey pixel with nonzero hue");

endmodule

// ===== rtl/hsv_div.sv =====
`timescale 1ns / 1ps

// Pipelined restoring divider, one quotient bit per register stage.
// Requires dividend < divisor * 2^QUO_BITS; the remainder then fits DVS_BITS.
module hsv_div #(
  parameter int DVS_BITS = hsv_pkg::CHANNEL_BITS_DEF,
  parameter int QUO_BITS = hsv_pkg::MIN_QUO_BITS
) (
  input  logic                         clk,
  input  logic [DVS_BITS+QUO_BITS-1:0] dividend,
  input  logic [DVS_BITS-1:0]          divisor,
  output logic [QUO_BITS-1:0]          quotient
);

  localparam int DW = DVS_BITS + QUO_BITS;

  // Per-stage partial remainder, shifting dividend/quotient word, divisor copy
  logic [DVS_BITS-1:0] rem  [QUO_BITS];
  logic [QUO_BITS-1:0] word [QUO_BITS];
  logic [DVS_BITS-1:0] dvs  [QUO_BITS];

  genvar k;
  generate
    for (k = 0; k < QUO_BITS; k++) begin : g_step
      logic [DVS_BITS-1:0] rem_in;
      logic [QUO_BITS-1:0] word_in;
      logic [DVS_BITS-1:0] dvs_in;
      logic [DVS_BITS:0]   trial;
      logic [DVS_BITS:0]   trial_sub;
      logic                take;

      // Select the stage input: the operands at the head, else the previous stage
      if (k == 0) begin : g_head
        assign rem_in  = dividend[DW-1 -: DVS_BITS];
        assign word_in = dividend[QUO_BITS-1:0];
        assign dvs_in  = divisor;
      end else begin : g_body
        assign rem_in  = rem[k-1];
        assign word_in = word[k-1];
        assign dvs_in  = dvs[k-1];
      end

      // Bring down one dividend bit and try the subtraction
      assign trial     = {rem_in, word_in[QUO_BITS-1]};
      assign take      = trial >= {1'b0, dvs_in};
      assign trial_sub = trial - {1'b0, dvs_in};

      // Advance remainder and shift the quotient bit in
      always_ff @(posedge clk) begin
        rem[k]  <= take ? trial_sub[DVS_BITS-1:0] : trial[DVS_BITS-1:0];
        word[k] <= {word_in[QUO_BITS-2:0], take};
        dvs[k]  <= dvs_in;
      end
    end
  endgenerate

  assign quotient = word[QUO_BITS-1];

endmodule
